// ----- design/llsp_pkg.sv -----
package llsp_pkg;

	localparam int unsigned SLOT_COUNT = 64;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
	localparam int unsigned HEAD_W     = $clog2(SLOT_COUNT + 1);
	localparam int unsigned OP_W       = 2;

	localparam logic [HEAD_W-1:0] EMPTY_HEAD = HEAD_W'(SLOT_COUNT);
	localparam logic [HEAD_W-1:0] STEP_LIMIT = HEAD_W'(SLOT_COUNT);

	localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE_ALL = 2'd2;

	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_addr;
		logic               wr_link_en;
		logic               wr_val_en;
		logic [IDX_W-1:0]   wr_addr;
		logic [HEAD_W-1:0]  wr_link;
		logic [VALUE_W-1:0] wr_val;
	} mem_req_t;

	typedef struct packed {
		logic [HEAD_W-1:0]  link;
		logic [VALUE_W-1:0] value;
	} mem_rsp_t;

	typedef struct packed {
		logic              pool_full;
		logic              found;
		logic [HEAD_W-1:0] new_head;
	} result_t;

endpackage

// ----- design/llsp_store.sv -----
module llsp_store (
	input  logic               clk,
	input  logic               arst_n,
	input  llsp_pkg::mem_req_t req,
	output llsp_pkg::mem_rsp_t rsp
);

	logic [llsp_pkg::VALUE_W-1:0] val_mem  [llsp_pkg::SLOT_COUNT];
	logic [llsp_pkg::HEAD_W-1:0]  link_mem [llsp_pkg::SLOT_COUNT];
	logic [llsp_pkg::SLOT_COUNT-1:0] link_vld_q;

	logic [llsp_pkg::VALUE_W-1:0] val_s1;
	logic [llsp_pkg::HEAD_W-1:0]  link_s1;
	logic [llsp_pkg::IDX_W-1:0]   addr_s1;
	logic                         vld_s1;
	logic [llsp_pkg::IDX_W-1:0]   addr_dec;

	always_ff @(posedge clk) begin
		if (req.wr_val_en) begin
			val_mem[req.wr_addr] <= req.wr_val;
		end
		if (req.wr_link_en) begin
			link_mem[req.wr_addr] <= req.wr_link;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
		end else if (req.wr_link_en) begin
			link_vld_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			val_s1  <= val_mem[req.rd_addr];
			link_s1 <= link_mem[req.rd_addr];
			addr_s1 <= req.rd_addr;
			vld_s1  <= link_vld_q[req.rd_addr];
		end
	end

	// An entry never written since reset links to the slot below it; slot 0 links to the empty head.
	assign addr_dec = addr_s1 - llsp_pkg::IDX_W'(1);

	always_comb begin
		rsp.value = val_s1;
		if (vld_s1) begin
			rsp.link = link_s1;
		end else if (addr_s1 == '0) begin
			rsp.link = llsp_pkg::EMPTY_HEAD;
		end else begin
			rsp.link = {1'b0, addr_dec};
		end
	end

endmodule

// ----- design/llsp_ctrl.sv -----
module llsp_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [llsp_pkg::OP_W-1:0]    in_op,
	input  logic [llsp_pkg::HEAD_W-1:0]  in_head,
	input  logic [llsp_pkg::VALUE_W-1:0] in_value,
	output llsp_pkg::mem_req_t           mreq,
	input  llsp_pkg::mem_rsp_t           mrsp,
	output logic                         res_valid,
	input  logic                         res_ready,
	output llsp_pkg::result_t            res
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_PUSH_CHK  = 4'd1;
	localparam logic [3:0] ST_PUSH_WR   = 4'd2;
	localparam logic [3:0] ST_REM_CHK   = 4'd3;
	localparam logic [3:0] ST_REM_WAIT  = 4'd4;
	localparam logic [3:0] ST_REM_REL   = 4'd5;
	localparam logic [3:0] ST_FREE_CHK  = 4'd6;
	localparam logic [3:0] ST_FREE_WAIT = 4'd7;
	localparam logic [3:0] ST_RESP      = 4'd8;

	logic [3:0]                   state_q;
	logic [llsp_pkg::HEAD_W-1:0]  flh_q;
	logic [llsp_pkg::HEAD_W-1:0]  cur_q;
	logic [llsp_pkg::HEAD_W-1:0]  prev_q;
	logic [llsp_pkg::HEAD_W-1:0]  nxt_q;
	logic [llsp_pkg::HEAD_W-1:0]  cnt_q;
	logic [llsp_pkg::VALUE_W-1:0] val_q;
	logic [llsp_pkg::HEAD_W-1:0]  res_head_q;
	logic                         res_found_q;
	logic                         res_full_q;

	logic [llsp_pkg::HEAD_W-1:0] head_norm;
	logic                        cur_live;
	logic                        match;

	assign head_norm = (in_head >= llsp_pkg::EMPTY_HEAD) ? llsp_pkg::EMPTY_HEAD : in_head;
	assign cur_live  = (cur_q < llsp_pkg::EMPTY_HEAD) && (cnt_q != llsp_pkg::STEP_LIMIT);
	assign match     = (mrsp.value == val_q);

	assign in_ready      = (state_q == ST_IDLE);
	assign res_valid     = (state_q == ST_RESP);
	assign res.new_head  = res_head_q;
	assign res.found     = res_found_q;
	assign res.pool_full = res_full_q;

	always_comb begin
		mreq = '0;
		case (state_q)
			ST_PUSH_CHK: begin
				mreq.rd_en   = (flh_q < llsp_pkg::EMPTY_HEAD);
				mreq.rd_addr = flh_q[llsp_pkg::IDX_W-1:0];
			end
			ST_PUSH_WR: begin
				mreq.wr_link_en = 1'b1;
				mreq.wr_val_en  = 1'b1;
				mreq.wr_addr    = flh_q[llsp_pkg::IDX_W-1:0];
				mreq.wr_link    = res_head_q;
				mreq.wr_val     = val_q;
			end
			ST_REM_CHK, ST_FREE_CHK: begin
				mreq.rd_en   = cur_live;
				mreq.rd_addr = cur_q[llsp_pkg::IDX_W-1:0];
			end
			ST_REM_WAIT: begin
				mreq.wr_link_en = match && (prev_q < llsp_pkg::EMPTY_HEAD);
				mreq.wr_addr    = prev_q[llsp_pkg::IDX_W-1:0];
				mreq.wr_link    = mrsp.link;
			end
			ST_REM_REL, ST_FREE_WAIT: begin
				mreq.wr_link_en = 1'b1;
				mreq.wr_addr    = cur_q[llsp_pkg::IDX_W-1:0];
				mreq.wr_link    = flh_q;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flh_q   <= llsp_pkg::HEAD_W'(llsp_pkg::SLOT_COUNT - 1);
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (in_op)
							llsp_pkg::OP_PUSH:     state_q <= ST_PUSH_CHK;
							llsp_pkg::OP_REMOVE:   state_q <= ST_REM_CHK;
							llsp_pkg::OP_FREE_ALL: state_q <= ST_FREE_CHK;
							default:               state_q <= ST_RESP;
						endcase
					end
				end
				ST_PUSH_CHK: begin
					state_q <= (flh_q < llsp_pkg::EMPTY_HEAD) ? ST_PUSH_WR : ST_RESP;
				end
				ST_PUSH_WR: begin
					flh_q   <= mrsp.link;
					state_q <= ST_RESP;
				end
				ST_REM_CHK: begin
					state_q <= cur_live ? ST_REM_WAIT : ST_RESP;
				end
				ST_REM_WAIT: begin
					state_q <= match ? ST_REM_REL : ST_REM_CHK;
				end
				ST_REM_REL: begin
					flh_q   <= cur_q;
					state_q <= ST_RESP;
				end
				ST_FREE_CHK: begin
					state_q <= cur_live ? ST_FREE_WAIT : ST_RESP;
				end
				ST_FREE_WAIT: begin
					flh_q   <= cur_q;
					state_q <= ST_FREE_CHK;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q       <= head_norm;
				prev_q      <= llsp_pkg::EMPTY_HEAD;
				cnt_q       <= '0;
				val_q       <= in_value;
				res_head_q  <= head_norm;
				res_found_q <= 1'b0;
				res_full_q  <= 1'b0;
			end
			ST_PUSH_CHK: begin
				res_full_q <= (flh_q >= llsp_pkg::EMPTY_HEAD);
			end
			ST_PUSH_WR: begin
				res_head_q <= flh_q;
			end
			ST_REM_WAIT: begin
				nxt_q <= mrsp.link;
				if (!match) begin
					prev_q <= cur_q;
					cur_q  <= mrsp.link;
					cnt_q  <= cnt_q + llsp_pkg::HEAD_W'(1);
				end
			end
			ST_REM_REL: begin
				res_found_q <= 1'b1;
				if (prev_q >= llsp_pkg::EMPTY_HEAD) begin
					res_head_q <= nxt_q;
				end
			end
			ST_FREE_CHK: begin
				res_head_q <= llsp_pkg::EMPTY_HEAD;
			end
			ST_FREE_WAIT: begin
				cur_q <= mrsp.link;
				cnt_q <= cnt_q + llsp_pkg::HEAD_W'(1);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_flh_range: assert property (@(posedge clk) disable iff (!arst_n)
		flh_q <= llsp_pkg::EMPTY_HEAD)
		else $error("Free list head is out of range.");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.rd_en && mreq.wr_link_en && (mreq.rd_addr == mreq.wr_addr)))
		else $error("Read and link write hit the same slot in one cycle.");

	a_read_before_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH_WR || state_q == ST_REM_WAIT || state_q == ST_FREE_WAIT)
		|-> $past(mreq.rd_en))
		else $error("Read data used without a read in the previous cycle.");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.found && res.pool_full))
		else $error("Found and pool full are both set.");
`endif

endmodule

// ----- design/linked_list_slot_pool.sv -----
// Push goes through the push check and push write states to the response state; a full pool skips the write.
// Remove visits each slot with a check and a wait state, and on a match releases it to the free list.
// Free-all visits each slot in the list with a check and a wait state; an unused op code goes to the response.
// One item at a time; the next can be accepted in the cycle after the output register loads.
// Reset clears the link valid bits and sets the free list head to the highest slot at once.
// No clearing pass is needed; slot values are undefined until written.
module linked_list_slot_pool (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // list_head [6:0], item_value [38:7]
	input  logic [1:0]  s_axis_tuser,  // op [1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // new_head [6:0], found [7], pool_full [8]
);

	llsp_pkg::mem_req_t mreq;
	llsp_pkg::mem_rsp_t mrsp;
	llsp_pkg::result_t  res;
	llsp_pkg::result_t  out_q;
	logic               res_valid;
	logic               res_ready;
	logic               out_valid_q;

	llsp_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	llsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_head   (s_axis_tdata[6:0]),
		.in_value  (s_axis_tdata[38:7]),
		.mreq      (mreq),
		.mrsp      (mrsp),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q.pool_full, out_q.found, out_q.new_head};

endmodule
